@@ sv/aazc_pkg.sv @@
package aazc_pkg;

    localparam int unsigned DEF_MAX_TRACKS = 16;

    // Restoring divider: one quotient bit per cycle over a 48-bit dividend.
    localparam int unsigned DIV_STEPS = 48;
    // Squares of dx, dy, dz and the radius go through one multiplier.
    localparam int unsigned SQ_STEPS  = 4;

    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_INC  = 32'd1013904223;
    localparam logic [31:0] SEED_MIX = 32'h9e3779b9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] PH_INACTIVE = 2'd0;
    localparam logic [1:0] PH_ACTIVE   = 2'd1;
    localparam logic [1:0] PH_LINGER   = 2'd2;

    typedef struct packed {
        logic signed [23:0] zone_x;
        logic signed [23:0] zone_y;
        logic signed [23:0] zone_z;
        logic [23:0]        zone_radius;
        logic               everywhere;
        logic [31:0]        min_break_ms;
        logic [31:0]        max_break_ms;
        logic [31:0]        linger_ms;
    } cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       dispatch;
        logic       sq_step;
        logic [1:0] sq_idx;
        logic       phase;
        logic       pick1;
        logic       pick2;
        logic       rd;
        logic       sched;
        logic       lvl;
        logic       mul;
        logic       div_step;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic range_bad;
        logic start_go;
        logic play_after;
        logic need_div;
    } stat_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [23:0] rnd24(input logic [31:0] s);
        logic [31:0] v;
        v = s * LCG_MUL + LCG_INC;
        return v[31:8];
    endfunction

endpackage

@@ sv/aazc_ctrl.sv @@
module aazc_ctrl
    import aazc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_PHASE = 4'd3;
    localparam logic [3:0] S_PICK1 = 4'd4;
    localparam logic [3:0] S_PICK2 = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_SCHED = 4'd7;
    localparam logic [3:0] S_LVL   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       started_reg, started_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.sq_idx     = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in  = 1'b1;
                    started_next = 1'b0;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.dispatch = 1'b1;
                cnt_next     = '0;
                state_next   = (st.is_add || st.range_bad) ? S_FIN : S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQ_STEPS - 1))
                    state_next = S_PHASE;
            end
            S_PHASE:
            begin
                cmd.phase    = 1'b1;
                started_next = st.start_go;
                if (st.start_go)
                    state_next = S_PICK1;
                else if (st.play_after)
                    state_next = S_RD;
                else
                    state_next = S_FIN;
            end
            S_PICK1:
            begin
                cmd.pick1  = 1'b1;
                state_next = S_PICK2;
            end
            S_PICK2:
            begin
                cmd.pick2  = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = started_reg ? S_SCHED : S_LVL;
            end
            S_SCHED:
            begin
                cmd.sched  = 1'b1;
                state_next = S_LVL;
            end
            S_LVL:
            begin
                cmd.lvl    = 1'b1;
                state_next = st.need_div ? S_MUL : S_FIN;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/aazc_dp.sv @@
module aazc_dp
    import aazc_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = DEF_MAX_TRACKS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  cmd_t         cmd,
    output stat_t        st,
    input  logic         in_cmd,
    input  logic [263:0] in_data,
    output logic [23:0]  out_data
);

    localparam int unsigned AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TRACKS + 1);

    // Item fields
    logic               cmd_reg;
    logic [31:0]        now_reg;
    logic signed [23:0] lx_reg, ly_reg, lz_reg;
    logic [15:0]        master_reg;
    logic [31:0]        seed_reg;
    logic [15:0]        ntl_reg;
    logic [31:0]        nfi_reg, nfo_reg, nlen_reg;

    // Track table: {length, fade_out, fade_in, level}
    logic [111:0] mem [MAX_TRACKS];
    logic [111:0] rd_reg;
    logic [15:0]  rd_level;
    logic [31:0]  rd_fi, rd_fo, rd_len;

    // Zone and playback state
    logic [1:0]         phase_reg;
    logic [31:0]        deact_reg;
    logic               playing_reg;
    logic               cur_valid_reg;
    logic [AW-1:0]      cur_reg;
    logic [31:0]        tst_reg, fie_reg, foe_reg, nst_reg;
    logic signed [32:0] fos_reg;
    logic [CW-1:0]      count_reg;

    // Work registers
    logic [49:0]        sq_reg, acc_reg;
    logic [23:0]        u1_reg, u2_reg;
    logic [24+CW-1:0]   pmul_reg;
    logic [55:0]        bmul_reg;
    logic [31:0]        brk_reg;
    logic [31:0]        numer_reg, den_reg;
    logic [47:0]        dvd_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        vol_reg;

    // Result fields
    logic [1:0] r_status_reg;
    logic       r_play_reg, r_stop_reg, r_lvl_on_reg;
    logic [3:0] r_tnum_reg;
    logic [23:0] out_reg;

    assign rd_level = rd_reg[15:0];
    assign rd_fi    = rd_reg[47:16];
    assign rd_fo    = rd_reg[79:48];
    assign rd_len   = rd_reg[111:80];
    assign out_data = out_reg;

    // Squared distance operand
    logic signed [24:0] diff;
    logic [24:0]        mag;
    always_comb
    begin
        unique case (cmd.sq_idx)
            2'd0:    diff = {cfg.zone_x[23], cfg.zone_x} - {lx_reg[23], lx_reg};
            2'd1:    diff = {cfg.zone_y[23], cfg.zone_y} - {ly_reg[23], ly_reg};
            2'd2:    diff = {cfg.zone_z[23], cfg.zone_z} - {lz_reg[23], lz_reg};
            default: diff = {1'b0, cfg.zone_radius};
        endcase
        mag = diff[24] ? 25'(-diff) : 25'(diff);
    end

    // Zone phase decision
    logic        in_range, going_off;
    logic [1:0]  phase_n;
    logic [31:0] deact_n;
    always_comb
    begin
        in_range  = cfg.everywhere || (acc_reg <= sq_reg);
        phase_n   = phase_reg;
        deact_n   = deact_reg;
        going_off = 1'b0;
        if (in_range)
        begin
            phase_n = PH_ACTIVE;
            if (phase_reg != PH_ACTIVE)
                deact_n = '0;
        end
        else if (phase_reg == PH_ACTIVE)
        begin
            phase_n = PH_LINGER;
            deact_n = sat_add(now_reg, cfg.linger_ms);
        end
        else if (phase_reg == PH_LINGER && now_reg > deact_reg)
        begin
            phase_n   = PH_INACTIVE;
            going_off = 1'b1;
        end
    end

    // Track pick with repeat avoidance
    logic [CW-1:0] pick_a, pick_b;
    always_comb
    begin
        pick_a = pmul_reg[24 +: CW];
        if (pick_a > count_reg - CW'(1))
            pick_a = count_reg - CW'(1);
        pick_b = pick_a;
        if (cur_valid_reg && pick_a == CW'(cur_reg) && count_reg > CW'(1))
            pick_b = (pick_a + CW'(1) == count_reg) ? '0 : pick_a + CW'(1);
    end

    // Schedule
    logic [31:0] foe_n;
    assign foe_n = sat_add(now_reg, rd_len);

    // Fade cases
    logic        fi_case, fo_case, end_case;
    logic [32:0] fo_den;
    always_comb
    begin
        fo_den   = 33'($signed({1'b0, foe_reg}) - fos_reg);
        fi_case  = (now_reg < fie_reg) && (fie_reg > tst_reg);
        fo_case  = ($signed({1'b0, now_reg}) >= fos_reg) && (now_reg < foe_reg) &&
                   ($signed({1'b0, foe_reg}) > fos_reg);
        end_case = (now_reg >= foe_reg);
    end

    // Divider step
    logic [32:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg, dvd_reg[47]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});

    assign st.is_add     = cmd_reg;
    assign st.range_bad  = (cfg.max_break_ms < cfg.min_break_ms);
    assign st.start_go   = (phase_n == PH_ACTIVE) && (count_reg != '0) && !playing_reg &&
                           (now_reg > nst_reg);
    assign st.play_after = playing_reg && !going_off;
    assign st.need_div   = fi_case || fo_case;

    // Table memory
    always_ff @(posedge clk)
    begin
        if (cmd.dispatch && cmd_reg && count_reg != CW'(MAX_TRACKS))
            mem[count_reg[AW-1:0]] <= {nlen_reg, nfo_reg, nfi_reg, ntl_reg};
        if (cmd.rd)
            rd_reg <= mem[cur_reg];
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg    <= in_cmd;
            now_reg    <= in_data[31:0];
            lx_reg     <= in_data[55:32];
            ly_reg     <= in_data[79:56];
            lz_reg     <= in_data[103:80];
            master_reg <= in_data[119:104];
            seed_reg   <= in_data[151:120];
            ntl_reg    <= in_data[167:152];
            nfi_reg    <= in_data[199:168];
            nfo_reg    <= in_data[231:200];
            nlen_reg   <= in_data[263:232];
        end
        if (cmd.sq_step)
        begin
            sq_reg <= 50'(mag * mag);
            if (cmd.sq_idx == 2'd0)
            begin
                acc_reg <= '0;
                u1_reg  <= rnd24(seed_reg);
                u2_reg  <= rnd24(seed_reg ^ SEED_MIX);
            end
            else
                acc_reg <= acc_reg + sq_reg;
        end
        if (cmd.pick1)
        begin
            pmul_reg <= (24+CW)'(u1_reg * count_reg);
            bmul_reg <= 56'((cfg.max_break_ms - cfg.min_break_ms) * u2_reg);
        end
        if (cmd.pick2)
            brk_reg <= cfg.min_break_ms + bmul_reg[55:24];
        if (cmd.lvl)
        begin
            if (fi_case)
            begin
                numer_reg <= (now_reg > tst_reg) ? now_reg - tst_reg : '0;
                den_reg   <= fie_reg - tst_reg;
            end
            else
            begin
                numer_reg <= foe_reg - now_reg;
                den_reg   <= fo_den[31:0];
            end
            vol_reg <= end_case && !fo_case ? '0 : rd_level;
        end
        if (cmd.mul)
        begin
            dvd_reg <= 48'(rd_level * numer_reg);
            rem_reg <= '0;
            vol_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[46:0], 1'b0};
            rem_reg <= q_bit ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            vol_reg <= {vol_reg[14:0], q_bit};
        end
        if (cmd.load_out)
            out_reg <= {(r_lvl_on_reg ? ((vol_reg < master_reg) ? vol_reg : master_reg) : 16'd0),
                        r_tnum_reg, r_stop_reg, r_play_reg, r_status_reg};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INACTIVE;
            deact_reg     <= '0;
            playing_reg   <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            tst_reg       <= '0;
            fie_reg       <= '0;
            foe_reg       <= '0;
            fos_reg       <= '0;
            nst_reg       <= '0;
            count_reg     <= '0;
            r_status_reg  <= ST_OK;
            r_play_reg    <= 1'b0;
            r_stop_reg    <= 1'b0;
            r_lvl_on_reg  <= 1'b0;
            r_tnum_reg    <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                r_status_reg <= ST_OK;
                r_play_reg   <= 1'b0;
                r_stop_reg   <= 1'b0;
                r_lvl_on_reg <= 1'b0;
                r_tnum_reg   <= '0;
            end
            if (cmd.dispatch)
            begin
                if (cmd_reg)
                begin
                    if (count_reg == CW'(MAX_TRACKS))
                        r_status_reg <= ST_FULL;
                    else
                    begin
                        count_reg  <= count_reg + CW'(1);
                        r_tnum_reg <= 4'(count_reg);
                    end
                end
                else if (st.range_bad)
                    r_status_reg <= ST_BAD_RANGE;
            end
            if (cmd.phase)
            begin
                phase_reg <= phase_n;
                deact_reg <= deact_n;
                if (going_off)
                begin
                    playing_reg   <= 1'b0;
                    cur_valid_reg <= 1'b0;
                    r_stop_reg    <= 1'b1;
                end
            end
            if (cmd.pick2)
                cur_reg <= pick_b[AW-1:0];
            if (cmd.sched)
            begin
                cur_valid_reg <= 1'b1;
                playing_reg   <= 1'b1;
                tst_reg       <= now_reg;
                fie_reg       <= sat_add(now_reg, rd_fi);
                foe_reg       <= foe_n;
                fos_reg       <= $signed({1'b0, foe_n}) - $signed({1'b0, rd_fo});
                nst_reg       <= sat_add(foe_n, brk_reg);
                r_play_reg    <= 1'b1;
                r_tnum_reg    <= 4'(cur_reg);
            end
            if (cmd.lvl)
            begin
                r_lvl_on_reg <= 1'b1;
                if (!fi_case && !fo_case && end_case)
                begin
                    playing_reg <= 1'b0;
                    r_stop_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

@@ sv/ambient_audio_zone_controller.sv @@
// Ambient audio zone controller. An item on the input stream either appends a track
// (tuser = 1) to a table of MAX_TRACKS entries or runs a tick (tuser = 0) that moves the
// zone through active, lingering and inactive, starts a random track with a random break
// after it, and reports play, stop, track number and the faded level capped by the master
// level. Every item gives exactly one result item. While a fade is in progress, the
// restoring divider forms the fade ratio. A result that is still waiting on the output
// adds its wait to the next item. One item is in work at a time; a finished result
// waits in the output register while the next item is accepted. Configuration registers
// sit on the APB port at byte address 4*i and are to be written only while idle; the
// block itself does not enforce this.
module ambient_audio_zone_controller
    import aazc_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = DEF_MAX_TRACKS
)
(
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_ms, listener_x, listener_y, listener_z, master_level, random_seed,
    // new_track_level, new_fade_in_ms, new_fade_out_ms, new_length_ms
    input  logic [263:0] s_axis_tdata,
    // cmd
    input  logic         s_axis_tuser,
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, start_play, stop_play, track_number, level_out
    output logic [23:0]  m_axis_tdata
);

    localparam logic [2:0] R_ZONE_X   = 3'd0;
    localparam logic [2:0] R_ZONE_Y   = 3'd1;
    localparam logic [2:0] R_ZONE_Z   = 3'd2;
    localparam logic [2:0] R_RADIUS   = 3'd3;
    localparam logic [2:0] R_EVERY    = 3'd4;
    localparam logic [2:0] R_MIN_BRK  = 3'd5;
    localparam logic [2:0] R_MAX_BRK  = 3'd6;
    localparam logic [2:0] R_LINGER   = 3'd7;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t st;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                R_ZONE_X:  cfg_reg.zone_x       <= pwdata[23:0];
                R_ZONE_Y:  cfg_reg.zone_y       <= pwdata[23:0];
                R_ZONE_Z:  cfg_reg.zone_z       <= pwdata[23:0];
                R_RADIUS:  cfg_reg.zone_radius  <= pwdata[23:0];
                R_EVERY:   cfg_reg.everywhere   <= pwdata[0];
                R_MIN_BRK: cfg_reg.min_break_ms <= pwdata;
                R_MAX_BRK: cfg_reg.max_break_ms <= pwdata;
                R_LINGER:  cfg_reg.linger_ms    <= pwdata;
                default:   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            R_ZONE_X:  prdata = {{8{cfg_reg.zone_x[23]}}, cfg_reg.zone_x};
            R_ZONE_Y:  prdata = {{8{cfg_reg.zone_y[23]}}, cfg_reg.zone_y};
            R_ZONE_Z:  prdata = {{8{cfg_reg.zone_z[23]}}, cfg_reg.zone_z};
            R_RADIUS:  prdata = {8'd0, cfg_reg.zone_radius};
            R_EVERY:   prdata = {31'd0, cfg_reg.everywhere};
            R_MIN_BRK: prdata = cfg_reg.min_break_ms;
            R_MAX_BRK: prdata = cfg_reg.max_break_ms;
            R_LINGER:  prdata = cfg_reg.linger_ms;
            default:   prdata = '0;
        endcase
    end

    aazc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    aazc_dp #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .st       (st),
        .in_cmd   (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule
